@@ rtl/afrf_pkg.sv @@
`default_nettype none

package afrf_pkg;

  localparam int TIME_FRAC_BITS_DEF = 16;

  localparam int FRAME_W   = 36;
  localparam int SETTLE_W  = 36;
  localparam int ELAPSED_W = 37;
  localparam int FPS_W     = 32;
  localparam int GATE_W    = 61;
  localparam int GATE_FRAC = 24;
  localparam int ALPHA_FRAC = 30;
  localparam int FPS_FRAC  = 12;
  localparam int QUO_W     = 64;
  localparam int MA_W      = 64;
  localparam int MB_W      = 31;
  localparam int GMAG_W    = 41;
  localparam int W_W       = 45;
  localparam int TAU_W     = 30;
  localparam int BETA_SHIFT = 16;

  localparam logic [FRAME_W-1:0]  MAX_FRAME_NS = 36'd10000000000;
  localparam logic [TAU_W-1:0]    TAU_GATE_NS  = 30'd318309886;
  localparam logic [W_W-1:0]      W_BASE       = 45'd15812154;
  localparam logic [MB_W-1:0]     W_BETA_Q16   = 31'd1441212;
  localparam logic [GMAG_W-1:0]   GATE_CAP     = 41'h100_0000_0000;
  localparam logic [53:0]         TAU_NUM      = 54'd16777216000000000;
  localparam logic [29:0]         ONE_SEC_NS   = 30'd1000000000;
  localparam logic [SETTLE_W-1:0] SETTLE_RST   = 36'd1000000000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PREP,
    S_SEED,
    S_REL_GO,
    S_REL_WT,
    S_AG_GO,
    S_AG_WT,
    S_GD_PRE,
    S_GD_GO,
    S_GD_WT,
    S_W_GO,
    S_W_WT,
    S_TAU_GO,
    S_TAU_WT,
    S_AF_GO,
    S_AF_WT,
    S_FT_GO,
    S_FT_WT,
    S_FPS_GO,
    S_FPS_WT,
    S_OUT
  } afrf_state_e;

endpackage

`default_nettype wire

@@ rtl/afrf_div.sv @@
`default_nettype none

module afrf_div import afrf_pkg::*; #(
  parameter int NUM_W = 76,
  parameter int DEN_W = 53
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, rem_q, rem_d;
  logic [QUO_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   rem_sh, sub;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_q, num_q[NUM_W-1]};
    sub    = rem_sh - {1'b0, den_q};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

@@ rtl/afrf_mul.sv @@
`default_nettype none

module afrf_mul import afrf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [MA_W-1:0]      a_i,
  input  wire logic [MB_W-1:0]      b_i,
  output logic                      done_o,
  output logic [MA_W+MB_W-1:0]      prod_o
);

  localparam int PW    = MA_W + MB_W;
  localparam int CNT_W = $clog2(MB_W + 1);

  logic [MA_W-1:0]  a_q;
  logic [MB_W-1:0]  b_q;
  logic [PW-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  // msb first shift and add, one multiplier bit per cycle
  assign acc_d = {acc_q[PW-2:0], 1'b0} + (b_q[MB_W-1] ? PW'(a_q) : PW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MB_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[MB_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

@@ rtl/adaptive_frame_rate_filter_core.sv @@
`default_nettype none

// Adaptive frame rate filter: each input word is one frame duration in ns, each output
// word the frames per second (unsigned Q20.12, saturated) and a settled flag. A frame
// over 10 s clears the filter. Until settle_ns of frame time has accumulated, the frame
// time is seeded directly and the rate reads zero. Frames are handled one at a time:
// an unsettled frame is only seeded, the settling frame also runs the rate division,
// and a settled frame runs five divisions and three multiplications. N = 60 +
// TIME_FRAC_BITS is the bit length of the shared bit-serial divider; the multiplier
// is a 31-step shift-add unit. The next frame is taken as soon as the result is in
// the output register.

module adaptive_frame_rate_filter_core import afrf_pkg::*; #(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [SETTLE_W-1:0] cfg_settle_ns_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [FRAME_W-1:0]  frame_ns_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [FPS_W-1:0]         fps_value_o,
  output logic                     estimate_valid_o
);

  localparam int FT_W      = FRAME_W + TIME_FRAC_BITS;
  localparam int DIV_NUM_W = FT_W + GATE_FRAC;
  localparam int DEN_W     = FT_W + 1;
  localparam int PW        = MA_W + MB_W;

  afrf_state_e state_q, state_d;

  logic [SETTLE_W-1:0]  settle_q;
  logic [FRAME_W-1:0]   ns_q, dt_q;
  logic [FT_W-1:0]      ft_q, diff_q;
  logic [GATE_W-1:0]    gate_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic                 settled_q;
  logic                 rel_neg_q;
  logic [QUO_W-1:0]     rel_q, d_q;
  logic [MB_W-1:0]      alpha_q;
  logic [W_W-1:0]       w_q;
  logic [TAU_W-1:0]     tau_q;
  logic [FPS_W-1:0]     res_fps_q, out_fps_q;
  logic                 res_est_q, out_est_q, out_valid_q;

  logic                 div_start, div_done, mul_start, mul_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DEN_W-1:0]     div_den;
  logic [QUO_W-1:0]     quo;
  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [PW-1:0]        prod;

  logic [FT_W-1:0]      dt_fx, ft_w, diff_c;
  logic                 ft_lt;
  logic [GATE_W-1:0]    gabs;
  logic [GMAG_W-1:0]    gcap;
  logic [ELAPSED_W:0]   el_sum;
  logic                 out_free;

  always_comb begin
    dt_fx  = FT_W'(dt_q) << TIME_FRAC_BITS;
    ft_w   = (ft_q == '0) ? FT_W'(1) : ft_q;
    ft_lt  = dt_fx < ft_w;
    diff_c = ft_lt ? (ft_w - dt_fx) : (dt_fx - ft_w);
    gabs   = gate_q[GATE_W-1] ? (GATE_W'(0) - gate_q) : gate_q;
    gcap   = (gabs > GATE_W'(GATE_CAP)) ? GATE_CAP : gabs[GMAG_W-1:0];
    el_sum = {1'b0, elapsed_q} + (ELAPSED_W+1)'(ns_q);
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = S_PREP;
      end
      S_PREP: begin
        state_d = (ns_q > MAX_FRAME_NS) ? S_OUT : S_SEED;
      end
      S_SEED: begin
        if (settled_q) begin
          state_d = S_REL_GO;
        end else begin
          state_d = ({1'b0, settle_q} <= elapsed_q) ? S_FPS_GO : S_OUT;
        end
      end
      S_REL_GO: begin
        div_start = 1'b1;
        div_num   = {diff_c, GATE_FRAC'(0)};
        div_den   = DEN_W'(ft_w);
        state_d   = S_REL_WT;
      end
      S_REL_WT: if (div_done) state_d = S_AG_GO;
      S_AG_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(dt_q) << ALPHA_FRAC;
        div_den   = DEN_W'(dt_q) + DEN_W'(TAU_GATE_NS);
        state_d   = S_AG_WT;
      end
      S_AG_WT: if (div_done) state_d = S_GD_PRE;
      S_GD_PRE: state_d = S_GD_GO;
      S_GD_GO: begin
        mul_start = 1'b1;
        mul_a     = d_q[QUO_W-1] ? (QUO_W'(0) - d_q) : d_q;
        mul_b     = alpha_q;
        state_d   = S_GD_WT;
      end
      S_GD_WT: if (mul_done) state_d = S_W_GO;
      S_W_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(gcap);
        mul_b     = W_BETA_Q16;
        state_d   = S_W_WT;
      end
      S_W_WT: if (mul_done) state_d = S_TAU_GO;
      S_TAU_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(TAU_NUM);
        div_den   = DEN_W'(w_q);
        state_d   = S_TAU_WT;
      end
      S_TAU_WT: if (div_done) state_d = S_AF_GO;
      S_AF_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(dt_q) << ALPHA_FRAC;
        div_den   = DEN_W'(dt_q) + DEN_W'(tau_q);
        state_d   = S_AF_WT;
      end
      S_AF_WT: if (div_done) state_d = S_FT_GO;
      S_FT_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(diff_q);
        mul_b     = alpha_q;
        state_d   = S_FT_WT;
      end
      S_FT_WT: if (mul_done) state_d = S_FPS_GO;
      S_FPS_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(ONE_SEC_NS) << (TIME_FRAC_BITS + FPS_FRAC);
        div_den   = DEN_W'(ft_q);
        state_d   = S_FPS_WT;
      end
      S_FPS_WT: if (div_done) state_d = S_OUT;
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // filter state, config and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q    <= SETTLE_RST;
      ft_q        <= '0;
      gate_q      <= '0;
      elapsed_q   <= '0;
      settled_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) settle_q <= cfg_settle_ns_i;
      if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_PREP: begin
          if (ns_q > MAX_FRAME_NS) begin
            ft_q      <= '0;
            gate_q    <= '0;
            elapsed_q <= '0;
            settled_q <= 1'b0;
          end else begin
            elapsed_q <= el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];
          end
        end
        S_SEED: begin
          if (!settled_q) begin
            ft_q      <= dt_fx;
            gate_q    <= '0;
            settled_q <= {1'b0, settle_q} <= elapsed_q;
          end
        end
        S_REL_GO: ft_q <= ft_w;
        S_GD_WT: begin
          if (mul_done) begin
            gate_q <= d_q[QUO_W-1] ? gate_q - prod[ALPHA_FRAC +: GATE_W]
                                   : gate_q + prod[ALPHA_FRAC +: GATE_W];
          end
        end
        S_FT_WT: begin
          if (mul_done) begin
            ft_q <= rel_neg_q ? ft_q - prod[ALPHA_FRAC +: FT_W]
                              : ft_q + prod[ALPHA_FRAC +: FT_W];
          end
        end
        S_OUT: if (out_free) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (in_valid_i) ns_q <= frame_ns_i;
      S_PREP: begin
        dt_q      <= (ns_q == '0) ? FRAME_W'(1) : ns_q;
        res_fps_q <= '0;
        res_est_q <= 1'b0;
      end
      S_REL_GO: begin
        rel_neg_q <= ft_lt;
        diff_q    <= diff_c;
      end
      S_REL_WT: if (div_done) rel_q <= rel_neg_q ? (QUO_W'(0) - quo) : quo;
      S_AG_WT:  if (div_done) alpha_q <= quo[MB_W-1:0];
      S_GD_PRE: d_q <= rel_q - {{(QUO_W-GATE_W){gate_q[GATE_W-1]}}, gate_q};
      S_W_WT:   if (mul_done) w_q <= W_BASE + prod[BETA_SHIFT +: W_W];
      S_TAU_WT: if (div_done) tau_q <= quo[TAU_W-1:0];
      S_AF_WT:  if (div_done) alpha_q <= quo[MB_W-1:0];
      S_FPS_WT: begin
        // a zero frame time divides to all ones and saturates
        if (div_done) begin
          res_fps_q <= (quo[QUO_W-1:FPS_W] != '0) ? '1 : quo[FPS_W-1:0];
          res_est_q <= 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_fps_q <= res_fps_q;
          out_est_q <= res_est_q;
        end
      end
      default: ;
    endcase
  end

  afrf_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  afrf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign fps_value_o      = out_fps_q;
  assign estimate_valid_o = out_est_q;

  a_zero_when_unsettled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !estimate_valid_o |-> fps_value_o == '0)
    else $error("rate word nonzero without a settled estimate");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second frame taken while one is in flight");

  a_settled_ft_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled_q |-> ft_q != '0)
    else $error("settled with zero frame time");

  a_gate_clear_unsettled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !settled_q |-> gate_q == '0)
    else $error("deviation gate nonzero before settling");

  a_no_start_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !div_start && !mul_start)
    else $error("arithmetic unit restarted while busy");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import afrf_pkg::*;

  localparam int          IDLE_LIMIT  = 20000;
  localparam int          PHASE_ITEMS = 220;
  localparam logic [63:0] ELAPSED_MAX = (64'd1 << ELAPSED_W) - 1;
  localparam logic [63:0] FPS_MAX     = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [FPS_W-1:0] fps;
    logic             valid;
  } rate_t;

  typedef struct packed {
    logic [FRAME_W-1:0] ns;
    logic               typed;
    logic [FPS_W-1:0]   fps;
    logic               valid;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SETTLE_W-1:0] cfg_settle_ns_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [FRAME_W-1:0]  frame_ns_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [FPS_W-1:0]    fps_value_o;
  logic                estimate_valid_o;

  adaptive_frame_rate_filter_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_settle_ns_i (cfg_settle_ns_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .frame_ns_i      (frame_ns_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .fps_value_o     (fps_value_o),
    .estimate_valid_o(estimate_valid_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // filter state mirror
  logic [63:0] settle_q;
  logic [63:0] frame_time_q;
  longint      gate_q;
  logic [63:0] elapsed_q;
  bit          settled_q;

  rate_t rate_q[$];
  int    fail_cnt = 0;
  bit    quiet = 1'b0;
  bit    hold_req = 1'b0;
  int    idle_cnt = 0;
  logic [63:0] nominal_ns = 64'd16666667;

  function automatic logic [63:0] frac_div(logic [63:0] n, logic [63:0] d, int fb);
    logic [127:0] q;
    q = (128'(n) << fb) / d;
    return q[63:0];
  endfunction

  function automatic logic [63:0] scale_q30(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> ALPHA_FRAC;
    return p[63:0];
  endfunction

  function automatic logic [63:0] smoothing(logic [63:0] dt, logic [63:0] tau);
    logic [127:0] q;
    q = (128'(dt) << ALPHA_FRAC) / (dt + tau);
    return q[63:0];
  endfunction

  function automatic void clear_filter();
    frame_time_q = '0;
    gate_q = 0;
    elapsed_q = '0;
    settled_q = 1'b0;
  endfunction

  function automatic rate_t filter_frame(logic [FRAME_W-1:0] frame);
    logic [63:0] ns, dt, dt_fx, ft, rel, a, g, w, tau, mag, q;
    longint      rel_s, d;
    rate_t       r;
    ns = 64'(frame);
    r = '0;
    if (ns > 64'(MAX_FRAME_NS)) begin
      clear_filter();
      return r;
    end
    dt = (ns == 0) ? 64'd1 : ns;
    dt_fx = dt << TIME_FRAC_BITS_DEF;
    elapsed_q = (ELAPSED_MAX - elapsed_q < ns) ? ELAPSED_MAX : elapsed_q + ns;
    if (!settled_q) begin
      frame_time_q = dt_fx;
      gate_q = 0;
      settled_q = elapsed_q >= settle_q;
    end else begin
      ft = (frame_time_q == 0) ? 64'd1 : frame_time_q;
      if (dt_fx >= ft) begin
        rel = frac_div(dt_fx - ft, ft, GATE_FRAC);
        rel_s = longint'(rel);
      end else begin
        rel = frac_div(ft - dt_fx, ft, GATE_FRAC);
        rel_s = -longint'(rel);
      end
      a = smoothing(dt, 64'(TAU_GATE_NS));
      d = rel_s - gate_q;
      if (d >= 0) gate_q = gate_q + longint'(scale_q30(64'(d), a));
      else gate_q = gate_q - longint'(scale_q30(64'(-d), a));
      g = (gate_q < 0) ? 64'(-gate_q) : 64'(gate_q);
      if (g > 64'(GATE_CAP)) g = 64'(GATE_CAP);
      w = 64'(W_BASE) + ((g * 64'(W_BETA_Q16)) >> BETA_SHIFT);
      tau = 64'(TAU_NUM) / w;
      a = smoothing(dt, tau);
      if (dt_fx >= ft) begin
        mag = scale_q30(dt_fx - ft, a);
        ft = ft + mag;
      end else begin
        mag = scale_q30(ft - dt_fx, a);
        ft = ft - mag;
      end
      frame_time_q = ft;
    end
    r.valid = settled_q;
    if (!settled_q) r.fps = '0;
    else if (frame_time_q == 0) r.fps = '1;
    else begin
      q = frac_div(64'(ONE_SEC_NS) << TIME_FRAC_BITS_DEF, frame_time_q, FPS_FRAC);
      r.fps = (q > FPS_MAX) ? '1 : q[FPS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    int          sel;
    logic [63:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 70) v = nominal_ns + 64'($urandom_range(0, 4000000));
    else if (sel < 80) v = 64'($urandom_range(1, 200000000));
    else if (sel < 85) v = 64'($urandom_range(0, 1));
    else if (sel < 90) v = 64'(MAX_FRAME_NS) - 64'($urandom_range(0, 1000));
    else if (sel < 95) v = {$urandom, $urandom};
    else v = 64'd1 << $urandom_range(0, 33);
    return v[FRAME_W-1:0];
  endfunction

  task automatic send_frame(logic [FRAME_W-1:0] frame, bit typed, rate_t typed_rate);
    rate_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_ns_i <= frame;
    do @(posedge clk_i); while (!in_ready_o);
    r = filter_frame(frame);
    rate_q.push_back(typed ? typed_rate : r);
  endtask

  task automatic write_settle(logic [SETTLE_W-1:0] value);
    in_valid_i <= 1'b0;
    while (rate_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_settle_ns_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settle_q = 64'(value);
  endtask

  // receiver: checks results and throttles out_ready
  initial begin
    int stall;
    rate_t e;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (rate_q.size() == 0) begin
          $error("unexpected word: fps_value %0d estimate_valid %0b",
                 fps_value_o, estimate_valid_o);
          fail_cnt++;
        end else begin
          e = rate_q.pop_front();
          if (fps_value_o !== e.fps) begin
            $error("fps_value expected %0d actual %0d", e.fps, fps_value_o);
            fail_cnt++;
          end
          if (estimate_valid_o !== e.valid) begin
            $error("estimate_valid expected %0b actual %0b", e.valid, estimate_valid_o);
            fail_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 3000;
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  dir_row_t dir_tab [17] = '{
    '{36'd0,            1'b1, 32'd0,    1'b0},
    '{36'd10000000001,  1'b1, 32'd0,    1'b0},
    '{36'hF_FFFF_FFFF,  1'b1, 32'd0,    1'b0},
    '{36'd10000000000,  1'b1, 32'd409,  1'b1},
    '{36'd16666667,     1'b0, 32'd0,    1'b0},
    '{36'd16666667,     1'b0, 32'd0,    1'b0},
    '{36'd1,            1'b0, 32'd0,    1'b0},
    '{36'd0,            1'b0, 32'd0,    1'b0},
    '{36'd10000000000,  1'b0, 32'd0,    1'b0},
    '{36'd1,            1'b0, 32'd0,    1'b0},
    '{36'd10000000000,  1'b0, 32'd0,    1'b0},
    '{36'd1,            1'b0, 32'd0,    1'b0},
    '{36'd33333333,     1'b0, 32'd0,    1'b0},
    '{36'd10000000001,  1'b1, 32'd0,    1'b0},
    '{36'd500000000,    1'b1, 32'd0,    1'b0},
    '{36'd500000000,    1'b1, 32'd8192, 1'b1},
    '{36'd8000000,      1'b0, 32'd0,    1'b0}
  };

  logic [SETTLE_W-1:0] phase_settle [7] = '{
    36'd1000000000, 36'd0, 36'd1, 36'd50000000, 36'd0, 36'hF_FFFF_FFFF, 36'd20000000
  };

  initial begin
    int wait_cnt;
    clear_filter();
    settle_q = 64'(SETTLE_RST);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_frame(dir_tab[i].ns, dir_tab[i].typed, '{dir_tab[i].fps, dir_tab[i].valid});

    for (int p = 0; p < 7; p++) begin
      if (p == 4) write_settle(SETTLE_W'({$urandom, $urandom}));
      else write_settle(phase_settle[p]);
      nominal_ns = 64'($urandom_range(1000000, 60000000));
      quiet = (p == 6);
      if (p == 2) hold_req = 1'b1;
      // long frames walk elapsed time into saturation
      if (p == 5) repeat (16) send_frame(36'd10000000000, 1'b0, '0);
      repeat (PHASE_ITEMS) send_frame(pick_frame(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    wait_cnt = 0;
    while (rate_q.size() != 0 && wait_cnt < IDLE_LIMIT) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && rate_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
